// ----- design/steering_profile_sampler_macros.svh -----
// assertion macros for the steering profile sampler
`ifndef STEERING_PROFILE_SAMPLER_MACROS_SVH
`define STEERING_PROFILE_SAMPLER_MACROS_SVH
// property that holds whenever the block is out of reset
`define SPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// property checked at every edge, reset included
`define SPS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

// ----- design/sps_pkg.sv -----
// package of the steering profile sampler: constants, types, tables
package sps_pkg;
    localparam int MaxStages = 16;
    localparam int IdxW = $clog2(MaxStages);
    localparam int CntW = $clog2(MaxStages + 1);
    localparam int CordicSteps = 30;
    localparam logic [30:0] LimReset = 31'd134217728;
    localparam logic [31:0] IwbReset = 32'd6710886;
    localparam logic [30:0] HalfPiCeil = 31'd421657429;
    localparam logic [16:0] CertOne = 17'd65536;

    localparam logic [1:0] ActClear = 2'd0;
    localparam logic [1:0] ActAppend = 2'd1;
    localparam logic [1:0] ActQuery = 2'd2;

    localparam logic CfgLimit = 1'b0;
    localparam logic CfgIwb = 1'b1;

    localparam logic [3:0] StOk = 4'd0;
    localparam logic [3:0] StElapsed = 4'd1;
    localparam logic [3:0] StSequence = 4'd2;
    localparam logic [3:0] StLimit = 4'd3;
    localparam logic [3:0] StWheelbase = 4'd4;
    localparam logic [3:0] StCert = 4'd5;
    localparam logic [3:0] StInitOver = 4'd6;
    localparam logic [3:0] StDuration = 4'd7;
    localparam logic [3:0] StHorizon = 4'd8;
    localparam logic [3:0] StSampledOver = 4'd9;
    localparam logic [3:0] StCurvOvf = 4'd10;

    typedef logic [IdxW-1:0] t_idx;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0: v = 32'h3243F6A8; 5'd1: v = 32'h1DAC6705; 5'd2: v = 32'h0FADBAFC;
            5'd3: v = 32'h07F56EA6; 5'd4: v = 32'h03FEAB76; 5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA; 5'd7: v = 32'h007FFF55; 5'd8: v = 32'h003FFFEA;
            5'd9: v = 32'h001FFFFD; 5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF; 5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF; 5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF; 5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF; 5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F; 5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008; 5'd28: v = 32'h00000004; 5'd29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage

// ----- design/sps_ram.sv -----
// generic single-port ram with registered read
module sps_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- design/sps_div.sv -----
// restoring divider: 64-bit numerator by 34-bit divisor, one bit a cycle
module sps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [33:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_quot, n_quot;
    logic [33:0] r_rem, n_rem;
    logic [33:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done;
    logic [34:0] w_sh;

    always_comb begin
        n_quot = r_quot;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        w_sh = {r_rem, r_quot[63]};
        if (r_busy) begin
            n_quot = {r_quot[62:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = 34'(w_sh - {1'b0, r_den});
                n_quot[0] = 1'b1;
            end else begin
                n_rem = w_sh[33:0];
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= r_busy && !n_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 7'd64;
            end else begin
                r_busy <= n_busy;
                r_cnt <= n_cnt;
            end
        end
        if (i_start) begin
            r_quot <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else begin
            r_quot <= n_quot;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- design/steering_profile_sampler.sv -----
// steering profile sampler: stage store, profile walk, tangent and curvature
// clear and append are done in the idle state; a query over n stages sums the stage
// durations into the horizon, walks the stages, then runs the cordic iterations and
// the curvature divide before its result word is offered
// one query at a time: input stall is high from a query's acceptance until its result is taken
// synchronous active-low reset clears count, overflow flag and control, and loads config with its reset values
module steering_profile_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic signed [31:0] i_stage_rate,
    input  logic [31:0] i_stage_duration,
    input  logic signed [31:0] i_initial_steering,
    input  logic signed [32:0] i_elapsed_time,
    input  logic [16:0] i_certificate_violation,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic signed [31:0] o_sampled_steering,
    output logic signed [31:0] o_curvature,
    output logic [3:0]  o_stage_index,
    output logic [31:0] o_stage_elapsed,
    output logic [31:0] o_horizon_duration
);
    import sps_pkg::*;
    `include "steering_profile_sampler_macros.svh"

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HRD   = 9'b000000010,  // read duration for horizon sum
        S_HACC  = 9'b000000100,  // add duration into horizon
        S_WRD   = 9'b000001000,  // read rate and duration for the walk
        S_WMUL  = 9'b000010000,  // rate times time used
        S_WACC  = 9'b000100000,  // accumulate angle, check limit
        S_CORD  = 9'b001000000,  // cordic iterations
        S_DIV   = 9'b010000000,  // curvature division
        S_OUT   = 9'b100000000   // result word waits
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [30:0] r_lim;
    logic [31:0] r_iwb;

    // stage store control
    logic [CntW-1:0] r_count;
    logic            r_ovf;

    // query work registers
    logic [CntW-1:0] r_k;
    logic [32:0]     r_horizon;
    logic [31:0]     r_remaining;
    logic signed [41:0] r_steer;
    logic signed [31:0] r_rate;
    logic [31:0]     r_used;
    logic            r_last;
    logic [63:0]     r_prod;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [4:0]      r_ci;
    logic [32:0]     r_elapsed;
    logic            r_div_go;

    // result word
    logic [3:0]  r_status;
    logic [31:0] r_samp, r_curv, r_sel, r_hor;
    logic [3:0]  r_sidx;
    logic        r_ovalid;

    // memories
    logic        w_we;
    t_idx        w_addr;
    logic [31:0] w_rate_q, w_dur_q;

    sps_ram #(.Width(32), .Depth(MaxStages)) u_rate (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(i_stage_rate), .o_rdata(w_rate_q));
    sps_ram #(.Width(32), .Depth(MaxStages)) u_dur (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(i_stage_duration), .o_rdata(w_dur_q));

    // curvature divider
    logic        w_div_start, w_div_done;
    logic [63:0] w_div_num, w_div_quot;
    logic [33:0] w_cy_mag;
    sps_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(r_cx), .o_done(w_div_done), .o_quot(w_div_quot));

    logic w_acc;
    assign o_stall = (r_state != S_IDLE);
    assign w_acc = i_valid && (r_state == S_IDLE);
    assign w_we = w_acc && (i_action == ActAppend) && (r_count < CntW'(MaxStages));
    assign w_addr = (r_state == S_IDLE) ? r_count[IdxW-1:0] : r_k[IdxW-1:0];

    // query front checks, in priority order
    logic [3:0]  w_pre;
    logic [31:0] w_init_mag;
    always_comb begin
        w_init_mag = i_initial_steering[31] ? 32'(-i_initial_steering)
                                            : 32'(i_initial_steering);
        priority if (i_elapsed_time[32])                       w_pre = StElapsed;
        else if (r_count == '0 || r_ovf)                       w_pre = StSequence;
        else if (r_lim == '0 || r_lim >= HalfPiCeil)           w_pre = StLimit;
        else if (r_iwb == '0)                                  w_pre = StWheelbase;
        else if (i_certificate_violation > CertOne)            w_pre = StCert;
        else if (w_init_mag > {1'b0, r_lim})                   w_pre = StInitOver;
        else                                                   w_pre = StOk;
    end

    // walk arithmetic; one stage can move the angle by up to about 2^39
    logic [31:0] w_usedn;
    logic signed [41:0] w_inc, w_steer_n;
    logic [41:0] w_steer_mag;
    logic [40:0] w_pmag;
    always_comb begin
        w_pmag = 41'((r_prod + 64'd8388608) >> 24);
        w_inc = r_rate[31] ? -$signed({1'b0, w_pmag}) : $signed({1'b0, w_pmag});
        w_steer_n = r_steer + w_inc;
        w_steer_mag = w_steer_n[41] ? 42'(-w_steer_n) : 42'(w_steer_n);
        w_usedn = (r_remaining < w_dur_q) ? r_remaining : w_dur_q;
    end

    // cordic step
    logic signed [33:0] w_dx, w_dy, w_at;
    always_comb begin
        w_dx = r_cy >>> r_ci;
        w_dy = r_cx >>> r_ci;
        w_at = $signed({2'b00, atan_q30(r_ci)});
    end

    // divider starts on the first divide cycle, with the final cordic x, and
    // only when x is positive
    assign w_cy_mag = r_cy[33] ? 34'(-r_cy) : 34'(r_cy);
    assign w_div_num = 64'(w_cy_mag) * 64'(r_iwb) + 64'(r_cx[33:1]);
    assign w_div_start = r_div_go && !r_cx[33] && (r_cx != '0);

    logic w_out_take;
    assign w_out_take = r_ovalid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lim <= LimReset;
            r_iwb <= IwbReset;
            r_count <= '0;
            r_ovf <= 1'b0;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= (r_state == S_CORD) && (r_ci == 5'(CordicSteps - 1));
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgLimit: r_lim <= i_cfg_data[30:0];
                    CfgIwb:   r_iwb <= i_cfg_data;
                    default:  ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_action)
                            ActClear: begin
                                r_count <= '0;
                                r_ovf <= 1'b0;
                            end
                            ActAppend: begin
                                if (r_count < CntW'(MaxStages)) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            ActQuery: begin
                                r_status <= w_pre;
                                r_samp <= '0;
                                r_curv <= '0;
                                r_sidx <= '0;
                                r_sel <= '0;
                                r_hor <= '0;
                                r_elapsed <= i_elapsed_time;
                                r_remaining <= i_elapsed_time[31:0];
                                r_steer <= 42'(i_initial_steering);
                                r_horizon <= '0;
                                r_k <= '0;
                                if (w_pre == StOk) begin
                                    r_state <= S_HRD;
                                end else begin
                                    r_state <= S_OUT;
                                    r_ovalid <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_HRD: r_state <= S_HACC;
                S_HACC: begin
                    if (w_dur_q == '0 || (r_horizon + 33'(w_dur_q)) > 33'hFFFFFFFF) begin
                        r_status <= StDuration;
                        r_state <= S_OUT;
                        r_ovalid <= 1'b1;
                    end else if (r_k + 1'b1 == r_count) begin
                        r_hor <= 32'(r_horizon + 33'(w_dur_q));
                        r_k <= '0;
                        if (r_elapsed > (r_horizon + 33'(w_dur_q))) begin
                            r_status <= StHorizon;
                            r_state <= S_OUT;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_state <= S_WRD;
                        end
                    end else begin
                        r_horizon <= r_horizon + 33'(w_dur_q);
                        r_k <= r_k + 1'b1;
                        r_state <= S_HRD;
                    end
                end
                S_WRD: r_state <= S_WMUL;
                S_WMUL: begin
                    r_rate <= $signed(w_rate_q);
                    r_used <= w_usedn;
                    r_last <= (r_remaining <= w_dur_q) || (r_k + 1'b1 == r_count);
                    r_remaining <= r_remaining - w_usedn;
                    r_prod <= 64'(w_rate_q[31] ? 32'(-$signed(w_rate_q)) : w_rate_q)
                              * 64'(w_usedn);
                    r_state <= S_WACC;
                end
                S_WACC: begin
                    r_steer <= w_steer_n;
                    r_sidx <= 4'(r_k);
                    r_sel <= r_used;
                    if (w_steer_mag > 42'(r_lim)) begin
                        r_status <= StSampledOver;
                        r_samp <= (w_steer_n > 42'sd2147483647) ? 32'h7FFFFFFF :
                                  (w_steer_n < -42'sd2147483648) ? 32'h80000000 :
                                  w_steer_n[31:0];
                        r_state <= S_OUT;
                        r_ovalid <= 1'b1;
                    end else if (r_last) begin
                        r_samp <= w_steer_n[31:0];
                        r_cx <= 34'sd1073741824;
                        r_cy <= '0;
                        r_cz <= 34'(w_steer_mag) <<< 2;
                        r_ci <= '0;
                        r_state <= S_CORD;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_WRD;
                    end
                end
                S_CORD: begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - w_at;
                    end else begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + w_at;
                    end
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == 5'(CordicSteps - 1)) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cx[33] || r_cx == '0) begin
                        r_status <= StCurvOvf;
                        r_state <= S_OUT;
                        r_ovalid <= 1'b1;
                    end else if (w_div_done) begin
                        if (w_div_quot > 64'h7FFFFFFF) begin
                            r_status <= StCurvOvf;
                        end else begin
                            r_curv <= (r_cy[33] != r_steer[41]) ? 32'(-w_div_quot[31:0])
                                                                : w_div_quot[31:0];
                        end
                        r_state <= S_OUT;
                        r_ovalid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_out_take) begin
                        r_ovalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_status = r_status;
    assign o_sampled_steering = r_samp;
    assign o_curvature = r_curv;
    assign o_stage_index = r_sidx;
    assign o_stage_elapsed = r_sel;
    assign o_horizon_duration = r_hor;

    `SPS_ASSERT(a_out_in_state, o_valid == (r_state == S_OUT), "result valid outside output state")
    `SPS_ASSERT(a_count_bound, r_count <= CntW'(MaxStages), "stage count above store depth")
    `SPS_ASSERT(a_ok_no_ovf, (o_valid && o_status == StOk) |-> !r_ovf, "accepted with overflowed store")
    `SPS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !o_valid), "not idle after reset")
endmodule

// ----- bench/sps_checker.sv -----
// checker for the steering profile sampler: tracks the profile, predicts samples, compares
`timescale 1ns / 1ps
module sps_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_stage_rate,
    input  logic [31:0]        i_stage_duration,
    input  logic signed [31:0] i_initial_steering,
    input  logic signed [32:0] i_elapsed_time,
    input  logic [16:0]        i_certificate_violation,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [3:0]         i_status,
    input  logic signed [31:0] i_sampled_steering,
    input  logic signed [31:0] i_curvature,
    input  logic [3:0]         i_stage_index,
    input  logic [31:0]        i_stage_elapsed,
    input  logic [31:0]        i_horizon_duration,
    output int                 o_fail_count,
    output int                 o_pending
);
    import sps_pkg::*;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] steer;
        logic [31:0] curv;
        logic [3:0]  idx;
        logic [31:0] in_stage;
        logic [31:0] horizon;
    } t_sample;

    localparam logic [31:0] ArcTan [CordicSteps] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    logic [30:0] steer_limit;
    logic [31:0] inv_wheelbase;
    logic [31:0] rate_mem [MaxStages];
    logic [31:0] dur_mem [MaxStages];
    int          n_stages;
    logic        profile_overflow;
    t_sample     sample_q [$];

    // rate times time, rounded half away from zero, back to q4.28
    function automatic longint angle_step(input logic signed [31:0] rate, input longint t);
        logic [63:0] mag;
        logic [63:0] p;
        mag = (rate < 0) ? 64'(-longint'(rate)) : 64'(longint'(rate));
        p = (mag * 64'(t) + 64'd8388608) >> 24;
        return (rate < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic bit tan_curvature(input longint ang, output logic [31:0] curv);
        longint z, x, y, dx, dy;
        logic [63:0] ymag, q;
        curv = '0;
        z = ((ang < 0) ? -ang : ang) * 4;
        x = longint'(1) << 30;
        y = 0;
        for (int i = 0; i < CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ArcTan[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ArcTan[i]);
            end
        end
        if (x <= 0) return 0;
        ymag = (y < 0) ? 64'(-y) : 64'(y);
        q = (ymag * 64'(inv_wheelbase) + 64'(x) / 2) / 64'(x);
        if (q > 64'h7FFFFFFF) return 0;
        curv = ((y < 0) != (ang < 0)) ? -q[31:0] : q[31:0];
        return 1;
    endfunction

    function automatic t_sample sample_profile(input logic signed [31:0] init,
                                               input logic signed [32:0] elapsed,
                                               input logic [16:0] cert);
        t_sample r;
        longint  lim, horizon, remaining, dur, used, steer;
        logic [31:0] curv;
        r = '0;
        lim = longint'({33'b0, steer_limit});
        if (elapsed < 0) begin r.status = StElapsed; return r; end
        if (n_stages == 0 || profile_overflow) begin r.status = StSequence; return r; end
        if (lim == 0 || steer_limit >= HalfPiCeil) begin r.status = StLimit; return r; end
        if (inv_wheelbase == 0) begin r.status = StWheelbase; return r; end
        if (cert > CertOne) begin r.status = StCert; return r; end
        if (((init < 0) ? -longint'(init) : longint'(init)) > lim) begin
            r.status = StInitOver;
            return r;
        end
        horizon = 0;
        for (int k = 0; k < n_stages; k++) begin
            if (dur_mem[k] == 0) begin r.status = StDuration; return r; end
            horizon += longint'(dur_mem[k]);
            if (horizon > 64'hFFFFFFFF) begin r.status = StDuration; return r; end
        end
        r.horizon = horizon[31:0];
        if (longint'(elapsed) > horizon) begin r.status = StHorizon; return r; end
        remaining = longint'(elapsed);
        steer = longint'(init);
        for (int k = 0; k < n_stages; k++) begin
            dur = longint'(dur_mem[k]);
            used = (remaining < dur) ? remaining : dur;
            steer += angle_step(rate_mem[k], used);
            r.idx = 4'(k);
            r.in_stage = used[31:0];
            if (((steer < 0) ? -steer : steer) > lim) begin
                r.status = StSampledOver;
                if (steer > 64'sh7FFFFFFF) r.steer = 32'h7FFFFFFF;
                else if (steer < -64'sh80000000) r.steer = 32'h80000000;
                else r.steer = steer[31:0];
                return r;
            end
            if (remaining <= dur) break;
            remaining -= dur;
        end
        r.steer = steer[31:0];
        if (!tan_curvature(steer, curv)) begin r.status = StCurvOvf; return r; end
        r.curv = curv;
        r.status = StOk;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    assign o_pending = sample_q.size();

    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            steer_limit <= LimReset;
            inv_wheelbase <= IwbReset;
            n_stages <= 0;
            profile_overflow <= 1'b0;
            sample_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CfgLimit) steer_limit <= i_cfg_data[30:0];
                else inv_wheelbase <= i_cfg_data;
            end
            if (i_valid && !i_in_stall) begin
                case (i_action)
                    ActClear: begin
                        n_stages <= 0;
                        profile_overflow <= 1'b0;
                    end
                    ActAppend: begin
                        if (n_stages < MaxStages) begin
                            rate_mem[n_stages] <= i_stage_rate;
                            dur_mem[n_stages] <= i_stage_duration;
                            n_stages <= n_stages + 1;
                        end else begin
                            profile_overflow <= 1'b1;
                        end
                    end
                    ActQuery: sample_q.push_back(sample_profile(i_initial_steering,
                        i_elapsed_time, i_certificate_violation));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    $display("%0t: unexpected sample, actual status %0d", $time, i_status);
                    o_fail_count++;
                end else begin
                    want = sample_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("sampled_steering", want.steer, i_sampled_steering);
                    check_field("curvature", want.curv, i_curvature);
                    check_field("stage_index", 32'(want.idx), 32'(i_stage_index));
                    check_field("stage_elapsed", want.in_stage, i_stage_elapsed);
                    check_field("horizon_duration", want.horizon, i_horizon_duration);
                end
            end
        end
    end

    initial o_fail_count = 0;
endmodule

// ----- bench/tb_top.sv -----
// top of the steering profile sampler testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
    import sps_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int DrainCycles = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_action = ActClear;
    logic signed [31:0] i_stage_rate = '0;
    logic [31:0]        i_stage_duration = '0;
    logic signed [31:0] i_initial_steering = '0;
    logic signed [32:0] i_elapsed_time = '0;
    logic [16:0]        i_certificate_violation = '0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CfgLimit;
    logic [31:0]        i_cfg_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic [3:0]         o_status;
    logic signed [31:0] o_sampled_steering;
    logic signed [31:0] o_curvature;
    logic [3:0]         o_stage_index;
    logic [31:0]        o_stage_elapsed;
    logic [31:0]        o_horizon_duration;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int sender_idle = 0;       // percent of words the sender precedes with a gap
    int receiver_idle = 0;     // percent of cycles the receiver stalls
    int hold_cycles = 0;       // long receiver hold-off, counted down below
    int words_sent = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    steering_profile_sampler u_top (.*);

    sps_checker u_check (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_action, .i_stage_rate,
        .i_stage_duration, .i_initial_steering, .i_elapsed_time, .i_certificate_violation,
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_sampled_steering(o_sampled_steering),
        .i_curvature(o_curvature), .i_stage_index(o_stage_index),
        .i_stage_elapsed(o_stage_elapsed), .i_horizon_duration(o_horizon_duration),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stall, or a long hold-off when one is requested
    always begin
        @(negedge i_clk);
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < receiver_idle);
        end
    end

    // run limit
    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("steering_profile_sampler regression: fail");
        $finish;
    end

    // offer one word; called and returning at a falling edge
    // valid stays high between back-to-back words, it only drops for a gap
    task automatic send_word(input logic [1:0] act, input logic [31:0] rate,
                             input logic [31:0] dur, input logic [31:0] init,
                             input logic [32:0] elapsed, input logic [16:0] cert);
        if ($urandom_range(0, 99) < sender_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_action <= act;
        i_stage_rate <= rate;
        i_stage_duration <= dur;
        i_initial_steering <= init;
        i_elapsed_time <= elapsed;
        i_certificate_violation <= cert;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (act != 2'd3) words_sent++;
    endtask

    task automatic append_stage(input logic [31:0] rate, input logic [31:0] dur);
        send_word(ActAppend, rate, dur, $urandom, {$urandom, 1'b0}, 17'($urandom));
    endtask

    task automatic query(input logic [31:0] init, input logic [32:0] elapsed,
                         input logic [16:0] cert);
        send_word(ActQuery, $urandom, $urandom, init, elapsed, cert);
    endtask

    // registers change only with the block idle; clear and append leave no sample
    // behind to wait for, so give them the drain time as well
    task automatic settle_and_configure(input logic [30:0] lim, input logic [31:0] iwb);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (DrainCycles) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CfgLimit;
        i_cfg_data <= {1'b0, lim};
        @(negedge i_clk);
        i_cfg_index <= CfgIwb;
        i_cfg_data <= iwb;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // clear, a random profile (mostly short, rarely overfull), then a few queries into it
    task automatic profile_run();
        int     n_new;
        longint horizon;
        logic [31:0] dur;
        horizon = 0;
        send_word(ActClear, $urandom, $urandom, $urandom, {$urandom, 1'b1}, 17'($urandom));
        n_new = ($urandom_range(0, 99) < 6) ? $urandom_range(15, 18) : $urandom_range(1, 4);
        for (int k = 0; k < n_new; k++) begin
            case ($urandom_range(0, 19))
                0: dur = 32'd0;                              // invalid duration
                1: dur = $urandom_range(32'h80000000, 32'hFFFFFFFF);   // large, the horizon may overflow
                default: dur = $urandom_range(1, 32'h02000000);
            endcase
            horizon += dur;
            append_stage($urandom_range(0, 32'h08000000) - 32'h04000000, dur);
        end
        repeat ($urandom_range(1, 4)) begin
            query(($urandom_range(0, 3) == 0) ? 32'd0
                      : $urandom_range(0, 32'h04000000) - 32'h02000000,
                  ($urandom_range(0, 9) == 0) ? 33'(horizon + $urandom_range(0, 255))
                      : 33'($urandom_range(0, 32'(horizon))),
                  ($urandom_range(0, 19) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)));
        end
    endtask

    // anything at all, the unused action included
    task automatic noise_word();
        send_word(2'($urandom), $urandom, $urandom, $urandom, {$urandom, 1'($urandom)},
                  17'($urandom));
    endtask

    logic [30:0] phase_lim [7];
    logic [31:0] phase_iwb [7];
    int          phase_words [7];
    int          target;

    initial begin
        phase_lim = '{LimReset, 31'd0, HalfPiCeil - 31'd1, HalfPiCeil, 31'd1,
                      31'h7FFFFFFF, 31'd300000000};
        phase_iwb = '{IwbReset, 32'd16777216, 32'hFFFFFFFF, 32'd0, 32'd1,
                      32'd16777216, 32'd25165824};
        phase_words = '{330, 50, 330, 50, 330, 50, 330};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at the reset settings
        sender_idle = 38;
        receiver_idle = 70;
        query(32'd0, 33'd0, 17'd0);                          // empty profile
        append_stage(32'h7FFFFFFF, 32'd1);
        append_stage(32'h80000000, 32'hFFFFFFFF);
        query(32'd0, 33'd0, 17'd0);                          // horizon beyond 32 bits
        send_word(ActClear, '0, '0, '0, '0, '0);
        append_stage(32'd16777216, 32'd16777216);
        append_stage(-32'sd33554432, 32'd33554432);
        query(32'd0, 33'h100000000, 17'd0);                  // most negative elapsed
        query(32'd0, 33'd0, 17'd65537);                      // certificate just over one
        query(32'd0, 33'd0, 17'h1FFFF);
        query(32'd134217729, 33'd0, 17'd0);                  // initial just over limit
        query(32'h80000000, 33'd0, 17'd0);
        query(32'd134217728, 33'd0, 17'd65536);              // at limit, certificate one
        query(32'd0, 33'd50331648, 17'd0);                   // exactly at horizon
        query(32'd0, 33'd50331649, 17'd0);                   // just after horizon
        send_word(2'd3, $urandom, $urandom, $urandom, '0, '0);   // unused action
        append_stage(32'h7FFFFFFF, 32'd16777216);
        query(-32'sd134217728, 33'd67108864, 17'd0);         // angle runs past limit
        query(32'd0, 33'h0FFFFFFFF, 17'd0);                  // largest elapsed
        send_word(ActClear, '0, '0, '0, '0, '0);
        append_stage(32'd0, 32'd0);
        query(32'd0, 33'd0, 17'd0);                          // zero duration

        for (int p = 0; p < 7; p++) begin
            settle_and_configure(phase_lim[p], phase_iwb[p]);
            if (p == 2) begin
                sender_idle = 70;
                receiver_idle = 38;
                hold_cycles = 600;      // block fills and holds its input stall
            end else if (p == 5) begin
                sender_idle = 0;
                receiver_idle = 0;
            end
            target = words_sent + phase_words[p];
            while (words_sent < target) begin
                if ($urandom_range(0, 99) < 80) profile_run();
                else noise_word();
            end
        end

        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("steering_profile_sampler regression: pass");
        end else begin
            $display("steering_profile_sampler regression: fail");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/sps_pkg.sv
design/sps_ram.sv
design/sps_div.sv
design/steering_profile_sampler.sv
bench/sps_checker.sv
bench/tb_top.sv
